/* src/assert_macros.svh */
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* src/svm_pkg.sv */
// Package for the sample voice mixer: sizes, codes and controller commands
`default_nettype none
package svm_pkg;
  localparam int VOICES = 16;
  localparam int SLOTS = 8;
  localparam int FRAMES_PER_SLOT = 8192;
  localparam int VW = $clog2(VOICES);
  localparam int SW = 3;
  localparam int FW = 13;
  localparam int AW = SW + FW;
  localparam int PW = 14;
  localparam int MEM_DEPTH = SLOTS * FRAMES_PER_SLOT;

  localparam logic [2:0] MODE_TICK = 3'd0;
  localparam logic [2:0] MODE_NOTE_ON = 3'd1;
  localparam logic [2:0] MODE_ALL_OFF = 3'd2;
  localparam logic [2:0] MODE_WRITE = 3'd3;
  localparam logic [2:0] MODE_LENGTH = 3'd4;

  localparam logic CFG_NOTES = 1'b0;
  localparam logic CFG_VOLUMES = 1'b1;

  typedef struct packed {
    logic          all_off;     // clear all voices
    logic          write_len;   // latch length for in_slot
    logic          trig;        // allocate a voice for trig_slot
    logic [SW-1:0] trig_slot;
    logic          tick_clear;  // clear accumulators
    logic          tick_rd;     // step voice tick_voice: retire, wait or play
    logic          tick_acc;    // accumulate the product of the voice stepped before
    logic [VW-1:0] tick_voice;
    logic          tick_done;   // load result register
  } svm_cmd_t;

  typedef struct packed {
    logic          out_busy;    // result not yet taken
    logic [SLOTS-1:0] slot_hit;
  } svm_stat_t;
endpackage
`default_nettype wire

/* src/svm_if.sv */
// Valid/ready channel interfaces for the mixer
`default_nettype none
interface svm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [6:0]  pitch;
  logic [8:0]  velocity;
  logic [15:0] delay_ticks;
  logic [2:0]  slot_index;
  logic [12:0] frame_address;
  logic signed [15:0] left_word;
  logic signed [15:0] right_word;
  logic [13:0] length_frames;
  modport source(output valid, mode, pitch, velocity, delay_ticks, slot_index,
    frame_address, left_word, right_word, length_frames, input ready);
  modport sink(input valid, mode, pitch, velocity, delay_ticks, slot_index,
    frame_address, left_word, right_word, length_frames, output ready);
endinterface

interface svm_out_if;
  logic valid;
  logic ready;
  logic signed [19:0] mix_left;
  logic signed [19:0] mix_right;
  modport source(output valid, mix_left, mix_right, input ready);
  modport sink(input valid, mix_left, mix_right, output ready);
endinterface

interface svm_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/svm_datapath.sv */
// Mixer datapath: voice registers, sample memory, multiply and stereo sums
`default_nettype none
module svm_datapath import svm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire svm_cmd_t cmd,
  output svm_stat_t stat,
  input  wire logic [2:0]  in_mode,
  input  wire logic [6:0]  in_pitch,
  input  wire logic [8:0]  in_velocity,
  input  wire logic [15:0] in_delay,
  input  wire logic [2:0]  in_slot,
  input  wire logic [12:0] in_frame,
  input  wire logic signed [15:0] in_left,
  input  wire logic signed [15:0] in_right,
  input  wire logic [13:0] in_length,
  input  wire logic        in_accept,
  input  wire logic [63:0] slot_notes,
  input  wire logic [63:0] slot_volumes,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic signed [19:0] mix_left,
  output logic signed [19:0] mix_right
);
  `include "assert_macros.svh"

  logic [VOICES-1:0] voice_active;
  logic [SW-1:0] voice_slot [VOICES];
  logic [PW-1:0] voice_position [VOICES];
  logic [15:0]   voice_delay [VOICES];
  logic [8:0]    voice_gain [VOICES];
  logic [VW-1:0] steal_cursor;
  logic [PW-1:0] slot_length [SLOTS];
  logic signed [15:0] sample_left [MEM_DEPTH];
  logic signed [15:0] sample_right [MEM_DEPTH];

  logic signed [15:0] rd_left, rd_right;
  logic signed [16:0] gain_acc;      // gain*volume up to 32768, as signed
  logic signed [32:0] prod_left, prod_right;
  logic signed [24:0] acc_left, acc_right;
  logic          play_acc;
  logic [8:0]    note_gain;
  logic [15:0]   note_delay;

  // Lowest free voice, else the steal cursor
  logic          any_free;
  logic [VW-1:0] free_voice, pick;
  always_comb begin
    any_free = 1'b0;
    free_voice = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!voice_active[i]) begin
        any_free = 1'b1;
        free_voice = VW'(i);
      end
    end
    pick = any_free ? free_voice : steal_cursor;
  end

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      stat.slot_hit[s] = !slot_notes[8*s+7] && slot_notes[8*s +: 7] == in_pitch &&
        slot_length[s] != '0;
    end
    stat.out_busy = out_valid;
  end

  logic [SW-1:0] cv_slot;
  logic [PW-1:0] cv_len, cv_pos;
  logic [7:0]    cv_vol;
  logic [8:0]    vel_sat;
  always_comb begin
    cv_slot = voice_slot[cmd.tick_voice];
    cv_len = slot_length[cv_slot];
    cv_pos = voice_position[cmd.tick_voice];
    cv_vol = slot_volumes[8*cv_slot +: 8];
    if (cv_vol > 8'd128) cv_vol = 8'd128;
    vel_sat = (in_velocity > 9'd256) ? 9'd256 : in_velocity;
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_mode == MODE_WRITE) begin
      sample_left[{in_slot, in_frame}] <= in_left;
      sample_right[{in_slot, in_frame}] <= in_right;
    end
    rd_left <= sample_left[{cv_slot, cv_pos[FW-1:0]}];
    rd_right <= sample_right[{cv_slot, cv_pos[FW-1:0]}];
  end

  // note-on gain and delay held for the slot scan
  always_ff @(posedge clk) begin
    if (in_accept && in_mode == MODE_NOTE_ON) begin
      note_gain <= vel_sat;
      note_delay <= in_delay;
    end
  end

  // Floor of product / 2^15 via arithmetic shift
  logic signed [24:0] sc_left, sc_right;
  always_comb begin
    prod_left = rd_left * gain_acc;
    prod_right = rd_right * gain_acc;
    sc_left = 25'(prod_left >>> 15);
    sc_right = 25'(prod_right >>> 15);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_active <= '0;
      steal_cursor <= '0;
      for (int s = 0; s < SLOTS; s++) slot_length[s] <= '0;
      out_valid <= 1'b0;
      play_acc <= 1'b0;
    end else begin
      play_acc <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.all_off) voice_active <= '0;
      if (cmd.write_len)
        slot_length[in_slot] <= (in_length > 14'd8192) ? 14'd8192 : in_length;
      if (cmd.trig) begin
        if (!any_free) steal_cursor <= steal_cursor + 1'b1;
        voice_active[pick] <= 1'b1;
        voice_slot[pick] <= cmd.trig_slot;
        voice_position[pick] <= '0;
        voice_delay[pick] <= note_delay;
        voice_gain[pick] <= note_gain;
      end
      if (cmd.tick_rd && voice_active[cmd.tick_voice]) begin
        if (cv_len == '0 || cv_pos >= cv_len) begin
          voice_active[cmd.tick_voice] <= 1'b0;
        end else if (voice_delay[cmd.tick_voice] != '0) begin
          voice_delay[cmd.tick_voice] <= voice_delay[cmd.tick_voice] - 1'b1;
        end else begin
          play_acc <= 1'b1;
          gain_acc <= 17'(voice_gain[cmd.tick_voice] * cv_vol);
          voice_position[cmd.tick_voice] <= cv_pos + 1'b1;
          if (cv_pos + 1'b1 >= cv_len) voice_active[cmd.tick_voice] <= 1'b0;
        end
      end
      if (cmd.tick_clear) begin
        acc_left <= '0;
        acc_right <= '0;
      end else if (cmd.tick_acc && play_acc) begin
        acc_left <= acc_left + sc_left;
        acc_right <= acc_right + sc_right;
      end
      if (cmd.tick_done) begin
        out_valid <= 1'b1;
        mix_left <= (acc_left > 25'sd524287) ? 20'sd524287 :
                    (acc_left < -25'sd524288) ? -20'sd524288 : acc_left[19:0];
        mix_right <= (acc_right > 25'sd524287) ? 20'sd524287 :
                     (acc_right < -25'sd524288) ? -20'sd524288 : acc_right[19:0];
      end
    end
  end

  `ASSERT_NEXT(a_done_valid, clk, rst, cmd.tick_done, out_valid, "result not raised")
  `ASSERT_IMPL(a_no_overwrite, clk, rst, cmd.tick_done, !out_valid, "result overwritten")
  `ASSERT_IMPL(a_excl, clk, rst, cmd.trig, !cmd.tick_rd, "trigger during tick walk")
endmodule
`default_nettype wire

/* src/svm_ctrl.sv */
// Mixer controller: sequences note-on slot scan and the per-tick voice walk
`default_nettype none
module svm_ctrl import svm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic [2:0] in_mode,
  input  wire svm_stat_t stat,
  output svm_cmd_t  cmd
);
  `include "assert_macros.svh"
  typedef enum logic [2:0] {IDLE, NOTE, WALK, DRAIN, DONE} state_t;
  state_t state;
  logic [SW-1:0] slot_ctr;
  logic [VW:0]   voice_ctr;
  logic [SLOTS-1:0] hits;
  logic accept;

  assign in_ready = (state == IDLE) && !(in_mode == MODE_TICK && stat.out_busy);
  assign accept = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.all_off = accept && in_mode == MODE_ALL_OFF;
    cmd.write_len = accept && in_mode == MODE_LENGTH && 1'b1;
    cmd.tick_clear = accept && in_mode == MODE_TICK;
    cmd.trig = (state == NOTE) && hits[slot_ctr];
    cmd.trig_slot = slot_ctr;
    cmd.tick_voice = voice_ctr[VW-1:0];
    cmd.tick_rd = (state == WALK);
    cmd.tick_acc = (state == WALK && voice_ctr != '0) || state == DRAIN;
    cmd.tick_done = (state == DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      slot_ctr <= '0;
      voice_ctr <= '0;
      hits <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (accept && in_mode == MODE_NOTE_ON) begin
            hits <= stat.slot_hit;
            slot_ctr <= '0;
            state <= NOTE;
          end else if (accept && in_mode == MODE_TICK) begin
            voice_ctr <= '0;
            state <= WALK;
          end
        end
        NOTE: begin
          slot_ctr <= slot_ctr + 1'b1;
          if (slot_ctr == SW'(SLOTS - 1)) state <= IDLE;
        end
        WALK: begin
          voice_ctr <= voice_ctr + 1'b1;
          if (voice_ctr == (VW+1)'(VOICES - 1)) state <= DRAIN;
        end
        DRAIN: state <= DONE;
        DONE: state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_ready_idle, clk, rst, in_ready, state == IDLE, "ready outside idle")
  `ASSERT_NEXT(a_walk_end, clk, rst, state == DRAIN, state == DONE, "drain not followed")
  `ASSERT_IMPL(a_done_free, clk, rst, state == DONE, !stat.out_busy, "result slot busy")
endmodule
`default_nettype wire

/* src/sample_voice_mixer.sv */
// Top level of the sample voice mixer
// Drum sample player with 16 voices over 8 slots of 8192 stereo frames. Write
// items store sample words and slot lengths; a note-on scans the 8 slots one
// per cycle; a tick walks the 16 voices one per cycle through the shared
// sample memory read and multiplier, then drains and saturates. A tick is
// not accepted while the previous mix still waits at the output. No clearing
// pass after reset.
`default_nettype none
module sample_voice_mixer import svm_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  svm_in_if.sink   in_ch,
  svm_out_if.source out_ch,
  svm_cfg_if.sink  cfg
);
  svm_cmd_t cmd;
  svm_stat_t stat;
  logic [63:0] slot_notes, slot_volumes;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_notes <= 64'h8080808080808080;
      slot_volumes <= 64'h8080808080808080;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_NOTES) slot_notes <= cfg.data;
      if (cfg.index == CFG_VOLUMES) slot_volumes <= cfg.data;
    end
  end

  svm_ctrl u_ctrl (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_mode(in_ch.mode), .stat, .cmd
  );

  svm_datapath u_dp (
    .clk, .rst, .cmd, .stat,
    .in_mode(in_ch.mode), .in_pitch(in_ch.pitch), .in_velocity(in_ch.velocity),
    .in_delay(in_ch.delay_ticks), .in_slot(in_ch.slot_index),
    .in_frame(in_ch.frame_address), .in_left(in_ch.left_word),
    .in_right(in_ch.right_word), .in_length(in_ch.length_frames),
    .in_accept(in_ch.valid && in_ch.ready),
    .slot_notes, .slot_volumes,
    .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .mix_left(out_ch.mix_left), .mix_right(out_ch.mix_right)
  );
endmodule
`default_nettype wire

/* tb/svm_mix_check.sv */
// Checker for the sample voice mixer: predicts every mix from accepted items and compares
`timescale 1ns / 100ps
`default_nettype none
module svm_mix_check import svm_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  svm_in_if  in_ch,
  svm_out_if out_ch,
  svm_cfg_if cfg,
  output int errors,
  output int pending
);
  logic [63:0] notes_reg;
  logic [63:0] volumes_reg;
  bit          v_on    [VOICES];
  logic [2:0]  v_slot  [VOICES];
  logic [13:0] v_pos   [VOICES];
  logic [15:0] v_wait  [VOICES];
  logic [8:0]  v_gain  [VOICES];
  logic [3:0]  steal_ptr;
  logic [13:0] slot_len [SLOTS];
  logic signed [15:0] pcm_l [MEM_DEPTH];
  logic signed [15:0] pcm_r [MEM_DEPTH];
  logic signed [19:0] want_l [$];
  logic signed [19:0] want_r [$];

  function automatic longint scaled(logic signed [15:0] s, int unsigned g);
    longint p;
    p = longint'(s) * longint'(g);
    return p >>> 15;
  endfunction

  function automatic logic signed [19:0] clip20(longint v);
    if (v > 524287) return 20'sd524287;
    if (v < -524288) return -20'sd524288;
    return v[19:0];
  endfunction

  task automatic trigger_note(input logic [6:0] pitch, input logic [8:0] vel,
                              input logic [15:0] dly);
    logic [7:0] b;
    int v;
    logic [8:0] g;
    g = (vel > 9'd256) ? 9'd256 : vel;
    for (int s = 0; s < SLOTS; s++) begin
      b = notes_reg[8*s +: 8];
      if (!b[7] && b[6:0] == pitch && slot_len[s] != 0) begin
        v = -1;
        for (int i = 0; i < VOICES; i++)
          if (v < 0 && !v_on[i]) v = i;
        if (v < 0) begin
          v = steal_ptr;
          steal_ptr = steal_ptr + 4'd1;
        end
        v_on[v] = 1'b1;
        v_slot[v] = s[2:0];
        v_pos[v] = '0;
        v_wait[v] = dly;
        v_gain[v] = g;
      end
    end
  endtask

  task automatic mix_tick(output longint l, output longint r);
    int s;
    int unsigned vol;
    int unsigned a;
    l = 0;
    r = 0;
    for (int v = 0; v < VOICES; v++) begin
      if (!v_on[v]) continue;
      s = v_slot[v];
      if (slot_len[s] == 0 || v_pos[v] >= slot_len[s]) begin
        v_on[v] = 1'b0;
        continue;
      end
      if (v_wait[v] > 0) begin
        v_wait[v] = v_wait[v] - 16'd1;
        continue;
      end
      vol = volumes_reg[8*s +: 8];
      if (vol > 128) vol = 128;
      a = s * FRAMES_PER_SLOT + v_pos[v];
      l += scaled(pcm_l[a], v_gain[v] * vol);
      r += scaled(pcm_r[a], v_gain[v] * vol);
      v_pos[v] = v_pos[v] + 14'd1;
      if (v_pos[v] >= slot_len[s]) v_on[v] = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    longint l, r;
    logic [13:0] len;
    if (rst) begin
      notes_reg = 64'h8080808080808080;
      volumes_reg = 64'h8080808080808080;
      for (int i = 0; i < VOICES; i++) begin
        v_on[i] = 0; v_slot[i] = 0; v_pos[i] = 0; v_wait[i] = 0; v_gain[i] = 0;
      end
      for (int s = 0; s < SLOTS; s++) slot_len[s] = 0;
      steal_ptr = 0;
      want_l.delete();
      want_r.delete();
      errors = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_NOTES) notes_reg = cfg.data;
        else volumes_reg = cfg.data;
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.mode)
          MODE_TICK: begin
            mix_tick(l, r);
            want_l.push_back(clip20(l));
            want_r.push_back(clip20(r));
          end
          MODE_NOTE_ON: trigger_note(in_ch.pitch, in_ch.velocity, in_ch.delay_ticks);
          MODE_ALL_OFF: for (int i = 0; i < VOICES; i++) v_on[i] = 1'b0;
          MODE_WRITE: begin
            pcm_l[{in_ch.slot_index, in_ch.frame_address}] = in_ch.left_word;
            pcm_r[{in_ch.slot_index, in_ch.frame_address}] = in_ch.right_word;
          end
          MODE_LENGTH: begin
            len = in_ch.length_frames;
            slot_len[in_ch.slot_index] = (len > FRAMES_PER_SLOT) ? 14'(FRAMES_PER_SLOT) : len;
          end
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (want_l.size() == 0) begin
          $display("%0t: mix with nothing expected, got L=%0d R=%0d", $time,
                   out_ch.mix_left, out_ch.mix_right);
          errors++;
        end else begin
          if (out_ch.mix_left !== want_l[0]) begin
            $display("%0t: mix_left expected %0d got %0d", $time, want_l[0],
                     out_ch.mix_left);
            errors++;
          end
          if (out_ch.mix_right !== want_r[0]) begin
            $display("%0t: mix_right expected %0d got %0d", $time, want_r[0],
                     out_ch.mix_right);
            errors++;
          end
          void'(want_l.pop_front());
          void'(want_r.pop_front());
        end
      end
    end
    pending = want_l.size();
  end
endmodule
`default_nettype wire

/* tb/sample_voice_mixer_test.sv */
// Testbench top for the sample voice mixer: stimulus, output stalls and verdict
`timescale 1ns / 100ps
`default_nettype none
module sample_voice_mixer_test;
  import svm_pkg::*;

  localparam int LIMIT = 1000000;

  typedef struct {
    logic [2:0]  mode;
    logic [6:0]  pitch;
    logic [8:0]  velocity;
    logic [15:0] delay_ticks;
    logic [2:0]  slot_index;
    logic [12:0] frame_address;
    logic signed [15:0] left_word;
    logic signed [15:0] right_word;
    logic [13:0] length_frames;
  } item_t;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   cycles;
  int   send_idle;
  int   recv_idle;
  bit   hold_go;
  bit   hold_done;
  int   hold_cnt;
  bit   written [MEM_DEPTH];
  int   prefix [SLOTS];
  logic [63:0] notes_now;

  svm_in_if  in_ch ();
  svm_out_if out_ch ();
  svm_cfg_if cfg ();

  sample_voice_mixer dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg));

  svm_mix_check checker_i (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg),
                           .errors(errors), .pending(pending));

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stalls, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic item_t noise_item();
    item_t it;
    it.mode = 3'($urandom_range(7));
    it.pitch = 7'($urandom);
    it.velocity = 9'($urandom);
    it.delay_ticks = 16'($urandom);
    it.slot_index = 3'($urandom);
    it.frame_address = 13'($urandom);
    it.left_word = 16'($urandom);
    it.right_word = 16'($urandom);
    it.length_frames = 14'($urandom);
    return it;
  endfunction

  task automatic push(input item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    if (it.mode == MODE_WRITE) begin
      written[{it.slot_index, it.frame_address}] = 1'b1;
      while (prefix[it.slot_index] < FRAMES_PER_SLOT &&
             written[it.slot_index * FRAMES_PER_SLOT + prefix[it.slot_index]])
        prefix[it.slot_index]++;
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= it.mode;
    in_ch.pitch <= it.pitch;
    in_ch.velocity <= it.velocity;
    in_ch.delay_ticks <= it.delay_ticks;
    in_ch.slot_index <= it.slot_index;
    in_ch.frame_address <= it.frame_address;
    in_ch.left_word <= it.left_word;
    in_ch.right_word <= it.right_word;
    in_ch.length_frames <= it.length_frames;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_op(input logic [2:0] mode, input logic [6:0] pitch,
                         input logic [8:0] vel, input logic [15:0] dly,
                         input logic [2:0] slot, input logic [13:0] len);
    item_t it;
    it = noise_item();
    it.mode = mode;
    it.pitch = pitch;
    it.velocity = vel;
    it.delay_ticks = dly;
    it.slot_index = slot;
    it.length_frames = len;
    push(it);
  endtask

  task automatic send_sample(input logic [2:0] slot, input logic [12:0] frame,
                             input logic signed [15:0] l, input logic signed [15:0] r);
    item_t it;
    it = noise_item();
    it.mode = MODE_WRITE;
    it.slot_index = slot;
    it.frame_address = frame;
    it.left_word = l;
    it.right_word = r;
    push(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_reg(input logic [0:0] idx, input logic [63:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_NOTES) notes_now = value;
  endtask

  task automatic random_item();
    item_t it;
    int s;
    int pick;
    it = noise_item();
    s = it.slot_index;
    pick = $urandom_range(99);
    if (pick < 32) begin
      it.mode = MODE_TICK;
    end else if (pick < 58) begin
      it.mode = MODE_NOTE_ON;
      if ($urandom_range(9) < 8) it.pitch = notes_now[8 * $urandom_range(7) +: 7];
      it.delay_ticks = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    end else if (pick < 78) begin
      it.mode = MODE_WRITE;
      if ($urandom_range(9) < 7 && prefix[s] < 40) it.frame_address = 13'(prefix[s]);
      if ($urandom_range(3) == 0) it.right_word = it.left_word;
    end else if (pick < 91) begin
      it.mode = MODE_LENGTH;
      it.length_frames = 14'($urandom_range(prefix[s]));
    end else if (pick < 95) begin
      it.mode = MODE_ALL_OFF;
    end else begin
      it.mode = 3'($urandom_range(5, 7));
    end
    push(it);
  endtask

  function automatic logic [63:0] random_notes();
    logic [63:0] n;
    logic [6:0] pool [4];
    pool = '{7'd36, 7'd38, 7'd42, 7'd127};
    for (int s = 0; s < SLOTS; s++)
      n[8*s +: 8] = ($urandom_range(4) == 0) ? {1'b1, 7'($urandom)} :
                    {1'b0, pool[$urandom_range(3)]};
    return n;
  endfunction

  initial begin
    logic [63:0] vol_set [4];
    logic [63:0] vr;
    rst = 1'b1;
    cycles = 0;
    send_idle = 0;
    recv_idle = 0;
    hold_go = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_TICK;
    in_ch.pitch = '0;
    in_ch.velocity = '0;
    in_ch.delay_ticks = '0;
    in_ch.slot_index = '0;
    in_ch.frame_address = '0;
    in_ch.left_word = '0;
    in_ch.right_word = '0;
    in_ch.length_frames = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    notes_now = 64'h8080808080808080;
    for (int s = 0; s < SLOTS; s++) prefix[s] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // preload short slots; some mono
    for (int s = 0; s < SLOTS; s++)
      for (int f = 0; f < 6; f++) begin
        vr = $urandom;
        send_sample(3'(s), 13'(f), vr[15:0], (s % 2) ? vr[15:0] : vr[31:16]);
      end
    send_sample(3'd7, 13'd8191, 16'sh8000, 16'sh7fff);
    send_sample(3'd0, 13'd6, 16'sh7fff, 16'sh8000);
    send_sample(3'd0, 13'd7, 16'sh8000, 16'sh7fff);
    for (int s = 0; s < SLOTS; s++) send_op(MODE_LENGTH, 0, 0, 0, 3'(s), 14'(prefix[s]));

    // directed: unbound pitch, unknown modes, oversize length
    send_op(MODE_NOTE_ON, 7'd0, 9'd256, 16'd0, 0, 0);
    send_op(MODE_TICK, 0, 0, 0, 0, 0);
    send_op(3'd5, 0, 0, 0, 0, 0);
    send_op(3'd6, 0, 0, 0, 0, 0);
    send_op(3'd7, 0, 0, 0, 0, 0);
    send_op(MODE_ALL_OFF, 0, 0, 0, 0, 0);
    send_op(MODE_LENGTH, 0, 0, 0, 3'd7, 14'h3fff);
    send_op(MODE_LENGTH, 0, 0, 0, 3'd7, 14'd8192);
    send_op(MODE_LENGTH, 0, 0, 0, 3'd7, 14'(prefix[7]));
    drain();
    set_reg(CFG_NOTES, 64'h7f3c3c3c3c3c3c3c);
    set_reg(CFG_VOLUMES, 64'hffffffffffffffff);
    // full gain, delays, stealing, shortened and emptied slots, zero velocity
    send_op(MODE_NOTE_ON, 7'd60, 9'd511, 16'd0, 0, 0);
    send_op(MODE_NOTE_ON, 7'd60, 9'd256, 16'd2, 0, 0);
    send_op(MODE_NOTE_ON, 7'd60, 9'd128, 16'd0, 0, 0);
    send_op(MODE_NOTE_ON, 7'd127, 9'd0, 16'd65535, 0, 0);
    send_op(MODE_TICK, 0, 0, 0, 0, 0);
    send_op(MODE_LENGTH, 0, 0, 0, 3'd0, 14'd1);
    send_op(MODE_LENGTH, 0, 0, 0, 3'd1, 14'd0);
    send_op(MODE_TICK, 0, 0, 0, 0, 0);
    send_op(MODE_TICK, 0, 0, 0, 0, 0);
    send_op(MODE_TICK, 0, 0, 0, 0, 0);
    send_op(MODE_ALL_OFF, 0, 0, 0, 0, 0);
    send_op(MODE_TICK, 0, 0, 0, 0, 0);
    drain();

    vol_set = '{64'h0, 64'h8080808080808080, 64'hffffffffffffffff, 64'h0};
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 80; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 80; end
        default: begin send_idle = 24; recv_idle = 24; end
      endcase
      set_reg(CFG_NOTES, (ph == 3) ? 64'h0 : random_notes());
      vr = vol_set[ph];
      if (ph == 3)
        for (int s = 0; s < SLOTS; s++) vr[8*s +: 8] = 8'($urandom);
      set_reg(CFG_VOLUMES, vr);
      for (int n = 0; n < 160; n++) begin
        if (ph == 0 && n == 60) hold_go = 1'b1;
        random_item();
      end
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
+incdir+src
src/svm_pkg.sv
src/svm_if.sv
src/svm_datapath.sv
src/svm_ctrl.sv
src/sample_voice_mixer.sv
tb/svm_mix_check.sv
tb/sample_voice_mixer_test.sv
